/* sv/dns_response_a_record_extractor_defines.svh */
// assertion macros shared by the extractor modules
`ifndef DNS_RESPONSE_A_RECORD_EXTRACTOR_DEFINES_SVH
`define DNS_RESPONSE_A_RECORD_EXTRACTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dra_pkg.sv */
`default_nettype none

package dra_pkg;

    localparam int MAX_RECORDS_DEF = 16;
    localparam int MAX_MESSAGE_DEF = 512;

    localparam int CFG_DATA_W = 16;
    localparam int MAXREC_W   = 5;
    localparam int COUNT_W    = 5;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 3;

    localparam logic CFG_EXPECTED_ID = 1'b0;
    localparam logic CFG_MAX_RECORDS = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ID_BAD    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SERVER    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_QUESTION  = 3'd5;

    localparam logic KIND_ADDR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int HEADER_LEN = 12;
    localparam logic [7:0]  RCODE_MASK = 8'h0F;
    localparam logic [7:0]  PTR_MASK   = 8'hC0;
    localparam logic [3:0]  Q_FIXED_LAST  = 4'd3;
    localparam logic [3:0]  A_RDLEN_HI    = 4'd8;
    localparam logic [3:0]  A_RDLEN_LO    = 4'd9;
    localparam logic [15:0] TYPE_A     = 16'd1;
    localparam logic [15:0] RDLEN_IPV4 = 16'd4;

    typedef struct packed {
        logic                en;
        logic                bank;
        logic [ADDR_W-1:0]   data;
    } t_store_wr;

    typedef struct packed {
        logic                vld;
        logic                bank;
        logic [STATUS_W-1:0] status;
    } t_handoff;

endpackage

`default_nettype wire

/* sv/dra_parser.sv */
`default_nettype none

module dra_parser #(
    parameter int MAX_RECORDS = dra_pkg::MAX_RECORDS_DEF,
    parameter int MAX_MESSAGE = dra_pkg::MAX_MESSAGE_DEF,
    localparam int FCW = $clog2(MAX_RECORDS + 1),
    localparam int AW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [dra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_step,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_end_of_message,
    output dra_pkg::t_store_wr                  o_store_wr,
    output logic [AW-1:0]                       o_store_addr,
    output dra_pkg::t_handoff                   o_handoff,
    output logic [FCW-1:0]                      o_handoff_count
);

    localparam int OW = $clog2(MAX_MESSAGE + 1);
    localparam int LW = (FCW > dra_pkg::MAXREC_W) ? FCW : dra_pkg::MAXREC_W;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_LABEL,
        PH_PTR2,
        PH_FIXED,
        PH_RDATA,
        PH_DONE
    } t_phase;

    logic [15:0]                   r_expected_id;
    logic [dra_pkg::MAXREC_W-1:0]  r_max_records;
    logic [OW-1:0]                 r_offset,   n_offset;
    logic                          r_too_long, n_too_long;
    t_phase                        r_phase,    n_phase;
    logic [15:0]                   r_q,        n_q;
    logic [15:0]                   r_a,        n_a;
    logic [7:0]                    r_label,    n_label;
    logic [3:0]                    r_fidx,     n_fidx;
    logic [15:0]                   r_kind,     n_kind;
    logic [15:0]                   r_rd,       n_rd;
    logic [31:0]                   r_shift,    n_shift;
    logic [FCW-1:0]                r_found,    n_found;
    logic [2:0]                    r_pstat,    n_pstat;
    logic                          r_bank,     n_bank;

    logic [2:0]                    w_status;
    logic [15:0]                   w_rd_full;
    logic                          w_keep;

    function automatic logic f_below(input logic [FCW-1:0] found,
                                     input logic [dra_pkg::MAXREC_W-1:0] lim);
        return (LW'(found) < LW'(lim)) && (LW'(found) < LW'(MAX_RECORDS));
    endfunction

    function automatic t_phase f_begin(input logic [15:0] q, input logic [15:0] a,
                                       input logic below);
        if (q != 16'd0 || (a != 16'd0 && below)) begin
            return PH_NAME;
        end
        return PH_DONE;
    endfunction

    always_comb begin
        n_offset   = r_offset;
        n_too_long = r_too_long;
        n_phase    = r_phase;
        n_q        = r_q;
        n_a        = r_a;
        n_label    = r_label;
        n_fidx     = r_fidx;
        n_kind     = r_kind;
        n_rd       = r_rd;
        n_shift    = r_shift;
        n_found    = r_found;
        n_pstat    = r_pstat;
        n_bank     = r_bank;
        w_rd_full  = {r_rd[15:8], i_data_byte};
        w_keep     = (r_kind == dra_pkg::TYPE_A) && (w_rd_full == dra_pkg::RDLEN_IPV4);
        w_status   = dra_pkg::ST_OK;
        o_store_wr.en   = 1'b0;
        o_store_wr.bank = r_bank;
        o_store_wr.data = {r_shift[23:0], i_data_byte};
        o_store_addr    = r_found[AW-1:0];
        o_handoff.vld    = 1'b0;
        o_handoff.bank   = r_bank;
        o_handoff.status = dra_pkg::ST_OK;
        o_handoff_count  = '0;

        if (i_step && !r_too_long) begin
            if (r_offset >= OW'(MAX_MESSAGE)) begin
                n_too_long = 1'b1;
            end else begin
                n_offset = r_offset + OW'(1);
                case (r_phase)
                    PH_HEADER: begin
                        if (r_offset == OW'(0)) begin
                            n_shift = {24'd0, i_data_byte};
                        end else if (r_offset == OW'(1)) begin
                            if ({r_shift[7:0], i_data_byte} != r_expected_id) begin
                                n_pstat = dra_pkg::ST_ID_BAD;
                                n_phase = PH_DONE;
                            end
                        end else if (r_offset == OW'(3)) begin
                            if ((i_data_byte & dra_pkg::RCODE_MASK) != 8'd0) begin
                                n_pstat = dra_pkg::ST_SERVER;
                                n_phase = PH_DONE;
                            end
                        end else if (r_offset == OW'(4)) begin
                            n_q = {i_data_byte, 8'd0};
                        end else if (r_offset == OW'(5)) begin
                            n_q = {r_q[15:8], i_data_byte};
                        end else if (r_offset == OW'(6)) begin
                            n_a = {i_data_byte, 8'd0};
                        end else if (r_offset == OW'(7)) begin
                            n_a = {r_a[15:8], i_data_byte};
                        end else if (r_offset == OW'(dra_pkg::HEADER_LEN - 1)) begin
                            n_shift = '0;
                            n_phase = f_begin(r_q, r_a, f_below(r_found, r_max_records));
                        end
                    end
                    PH_NAME: begin
                        if (i_data_byte == 8'd0) begin
                            n_phase = PH_FIXED;
                            n_fidx  = '0;
                        end else if ((i_data_byte & dra_pkg::PTR_MASK) == dra_pkg::PTR_MASK) begin
                            n_phase = PH_PTR2;
                        end else begin
                            n_label = i_data_byte;
                            n_phase = PH_LABEL;
                        end
                    end
                    PH_LABEL: begin
                        n_label = r_label - 8'd1;
                        if (n_label == 8'd0) begin
                            n_phase = PH_NAME;
                        end
                    end
                    PH_PTR2: begin
                        n_phase = PH_FIXED;
                        n_fidx  = '0;
                    end
                    PH_FIXED: begin
                        if (r_q != 16'd0) begin
                            if (r_fidx >= dra_pkg::Q_FIXED_LAST) begin
                                n_q     = r_q - 16'd1;
                                n_phase = f_begin(n_q, r_a, f_below(r_found, r_max_records));
                            end else begin
                                n_fidx = r_fidx + 4'd1;
                            end
                        end else begin
                            if (r_fidx >= dra_pkg::A_RDLEN_LO) begin
                                n_rd    = w_rd_full;
                                n_shift = '0;
                                if (!w_keep) begin
                                    n_kind = '0;
                                end
                                if (w_rd_full == 16'd0) begin
                                    n_a     = r_a - 16'd1;
                                    n_phase = f_begin(r_q, n_a,
                                                      f_below(r_found, r_max_records));
                                end else begin
                                    n_phase = PH_RDATA;
                                end
                            end else begin
                                if (r_fidx == 4'd0) begin
                                    n_kind = {i_data_byte, 8'd0};
                                end else if (r_fidx == 4'd1) begin
                                    n_kind = {r_kind[15:8], i_data_byte};
                                end else if (r_fidx == dra_pkg::A_RDLEN_HI) begin
                                    n_rd = {i_data_byte, 8'd0};
                                end
                                n_fidx = r_fidx + 4'd1;
                            end
                        end
                    end
                    PH_RDATA: begin
                        if (r_kind == dra_pkg::TYPE_A) begin
                            n_shift = {r_shift[23:0], i_data_byte};
                        end
                        n_rd = r_rd - 16'd1;
                        if (n_rd == 16'd0) begin
                            if (r_kind == dra_pkg::TYPE_A && f_below(r_found, r_max_records)) begin
                                o_store_wr.en = 1'b1;
                                n_found       = r_found + FCW'(1);
                            end
                            n_a     = r_a - 16'd1;
                            n_phase = f_begin(r_q, n_a, f_below(n_found, r_max_records));
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (i_step && i_end_of_message) begin
            if (n_too_long) begin
                w_status = dra_pkg::ST_TOO_LONG;
            end else if (n_offset < OW'(dra_pkg::HEADER_LEN)) begin
                w_status = dra_pkg::ST_TOO_SHORT;
            end else if (n_pstat != dra_pkg::ST_OK) begin
                w_status = n_pstat;
            end else if (n_phase != PH_DONE && n_phase != PH_HEADER && n_q != 16'd0) begin
                w_status = dra_pkg::ST_QUESTION;
            end
            o_handoff.vld    = 1'b1;
            o_handoff.status = w_status;
            o_handoff_count  = (w_status == dra_pkg::ST_OK) ? n_found : '0;
            n_bank     = ~r_bank;
            n_offset   = '0;
            n_too_long = 1'b0;
            n_phase    = PH_HEADER;
            n_q        = '0;
            n_a        = '0;
            n_label    = '0;
            n_fidx     = '0;
            n_kind     = '0;
            n_rd       = '0;
            n_shift    = '0;
            n_found    = '0;
            n_pstat    = dra_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= '0;
            r_max_records <= dra_pkg::MAXREC_W'(dra_pkg::MAX_RECORDS_DEF);
            r_offset      <= '0;
            r_too_long    <= 1'b0;
            r_phase       <= PH_HEADER;
            r_q           <= '0;
            r_a           <= '0;
            r_label       <= '0;
            r_fidx        <= '0;
            r_kind        <= '0;
            r_rd          <= '0;
            r_shift       <= '0;
            r_found       <= '0;
            r_pstat       <= dra_pkg::ST_OK;
            r_bank        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dra_pkg::CFG_EXPECTED_ID: r_expected_id <= i_cfg_data;
                    dra_pkg::CFG_MAX_RECORDS:
                        r_max_records <= i_cfg_data[dra_pkg::MAXREC_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_offset   <= n_offset;
            r_too_long <= n_too_long;
            r_phase    <= n_phase;
            r_q        <= n_q;
            r_a        <= n_a;
            r_label    <= n_label;
            r_fidx     <= n_fidx;
            r_kind     <= n_kind;
            r_rd       <= n_rd;
            r_shift    <= n_shift;
            r_found    <= n_found;
            r_pstat    <= n_pstat;
            r_bank     <= n_bank;
        end
    end

    `include "dns_response_a_record_extractor_defines.svh"

    `DRA_ASSERT_NOW(a_found_bound, 1'b1, LW'(r_found) <= LW'(MAX_RECORDS), "found count past limit")
    `DRA_ASSERT_NOW(a_offset_bound, 1'b1, r_offset <= OW'(MAX_MESSAGE), "byte offset past limit")

endmodule

`default_nettype wire

/* sv/dra_emitter.sv */
`default_nettype none

module dra_emitter #(
    parameter int MAX_RECORDS = dra_pkg::MAX_RECORDS_DEF,
    localparam int FCW = $clog2(MAX_RECORDS + 1),
    localparam int AW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dra_pkg::t_store_wr            i_store_wr,
    input  wire logic [AW-1:0]                 i_store_addr,
    input  wire dra_pkg::t_handoff             i_handoff,
    input  wire logic [FCW-1:0]                i_handoff_count,
    output logic                               o_busy,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_item_kind,
    output logic [dra_pkg::ADDR_W-1:0]         o_address,
    output logic [dra_pkg::STATUS_W-1:0]       o_status,
    output logic [dra_pkg::COUNT_W-1:0]        o_record_count,
    output logic                               o_last
);

    localparam int DEPTH = 2 ** (AW + 1);

    logic [dra_pkg::ADDR_W-1:0]   r_mem [DEPTH];
    logic                         r_busy;
    logic                         r_bank;
    logic [FCW-1:0]               r_cnt;
    logic [FCW-1:0]               r_idx;
    logic [dra_pkg::STATUS_W-1:0] r_st;
    logic                         r_o_valid;
    logic                         r_kind;
    logic [dra_pkg::ADDR_W-1:0]   r_addr;
    logic [dra_pkg::STATUS_W-1:0] r_o_status;
    logic [dra_pkg::COUNT_W-1:0]  r_o_count;
    logic                         r_last;
    logic                         w_load;
    logic                         w_more;

    assign w_load = !r_o_valid || i_ready;
    assign w_more = r_idx < r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_store_wr.en) begin
            r_mem[{i_store_wr.bank, i_store_addr}] <= i_store_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (w_load) begin
                r_o_valid <= r_busy;
                if (r_busy) begin
                    if (w_more) begin
                        r_idx <= r_idx + FCW'(1);
                    end else begin
                        r_busy <= 1'b0;
                    end
                end
            end
            if (i_handoff.vld) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_handoff.vld) begin
            r_bank <= i_handoff.bank;
            r_cnt  <= i_handoff_count;
            r_st   <= i_handoff.status;
        end
        if (w_load && r_busy) begin
            r_o_count <= dra_pkg::COUNT_W'(r_cnt);
            if (w_more) begin
                r_kind     <= dra_pkg::KIND_ADDR;
                r_addr     <= r_mem[{r_bank, r_idx[AW-1:0]}];
                r_o_status <= dra_pkg::ST_OK;
                r_last     <= 1'b0;
            end else begin
                r_kind     <= dra_pkg::KIND_STATUS;
                r_addr     <= '0;
                r_o_status <= r_st;
                r_last     <= 1'b1;
            end
        end
    end

    assign o_busy         = r_busy;
    assign o_valid        = r_o_valid;
    assign o_item_kind    = r_kind;
    assign o_address      = r_addr;
    assign o_status       = r_o_status;
    assign o_record_count = r_o_count;
    assign o_last         = r_last;

    `include "dns_response_a_record_extractor_defines.svh"

    `DRA_ASSERT_NOW(a_no_overlap, i_handoff.vld, !r_busy, "handoff while results pending")
    `DRA_ASSERT_NOW(a_idx_bound, r_busy, r_idx <= r_cnt, "emit index past count")
    `DRA_ASSERT_NOW(a_err_empty, r_o_valid && r_last && r_o_status != dra_pkg::ST_OK,
        r_o_count == '0, "addresses sent with error status")
    `DRA_ASSERT_NEXT(a_stall_hold, r_o_valid && !i_ready, r_o_valid && $stable(r_addr),
        "result changed under stall")

endmodule

`default_nettype wire

/* sv/dns_response_a_record_extractor.sv */
// dns response a-record extractor
// input channel: one message byte per request on i_valid/o_ready, with
// i_end_of_message high on the final byte; the header id and rcode are
// checked, questions skipped, and type-1 answers with 4-byte rdata kept
// output channel: on o_valid/i_ready, the kept addresses of a message
// (o_item_kind 0), then one status request (o_item_kind 1, o_last 1)
// configuration: i_cfg_we with i_cfg_index 0 sets the expected id,
// index 1 sets the record limit; write only while the block is idle
// throughput: one byte per cycle, set by the input register feeding the
// single-cycle parse step
// latency: the first result of a message leaves 2 cycles after its final
// byte is accepted, then one result per cycle, count + 1 results in all
// a final byte waits in the input register while results of the previous
// message are still draining; bytes before it keep flowing
// an output stall holds the result register and backs up into the input
// reset: synchronous, clears parser and output control, expected id 0,
// record limit 16
`default_nettype none

module dns_response_a_record_extractor #(
    parameter int MAX_RECORDS = dra_pkg::MAX_RECORDS_DEF,
    parameter int MAX_MESSAGE = dra_pkg::MAX_MESSAGE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [dra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_end_of_message,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_item_kind,
    output logic [dra_pkg::ADDR_W-1:0]          o_address,
    output logic [dra_pkg::STATUS_W-1:0]        o_status,
    output logic [dra_pkg::COUNT_W-1:0]         o_record_count,
    output logic                                o_last
);

    localparam int FCW = $clog2(MAX_RECORDS + 1);
    localparam int AW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

    logic               r_in_vld;
    logic [7:0]         r_in_byte;
    logic               r_in_eom;
    logic               w_step;
    logic               w_busy;
    dra_pkg::t_store_wr w_store_wr;
    logic [AW-1:0]      w_store_addr;
    dra_pkg::t_handoff  w_handoff;
    logic [FCW-1:0]     w_handoff_count;

    assign w_step  = r_in_vld && (!r_in_eom || !w_busy);
    assign o_ready = !r_in_vld || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_eom  <= i_end_of_message;
        end
    end

    dra_parser #(
        .MAX_RECORDS(MAX_RECORDS),
        .MAX_MESSAGE(MAX_MESSAGE)
    ) u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_step           (w_step),
        .i_data_byte      (r_in_byte),
        .i_end_of_message (r_in_eom),
        .o_store_wr       (w_store_wr),
        .o_store_addr     (w_store_addr),
        .o_handoff        (w_handoff),
        .o_handoff_count  (w_handoff_count)
    );

    dra_emitter #(
        .MAX_RECORDS(MAX_RECORDS)
    ) u_emitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_store_wr      (w_store_wr),
        .i_store_addr    (w_store_addr),
        .i_handoff       (w_handoff),
        .i_handoff_count (w_handoff_count),
        .o_busy          (w_busy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_item_kind     (o_item_kind),
        .o_address       (o_address),
        .o_status        (o_status),
        .o_record_count  (o_record_count),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire
